// ===== src/mtfr_pkg.sv =====
package mtfr_pkg;

	localparam int ITEM_W      = 10;
	localparam int RANK_W      = 10;
	localparam int CNT_W       = 11;
	localparam int RESET_COUNT = 1024;

endpackage

// ===== src/mtfr_cell.sv =====
// One stack slot. The search token visits one slot per cycle: the slot takes
// the carried item and hands its old content down; a slot that holds the
// searched item takes the carried item too, and the token stops there.
module mtfr_cell #(
	parameter int CELL_W = 10,
	parameter int INDEX  = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              restore,
	input  logic [CELL_W-1:0] search,
	input  logic              tok_in_valid,
	input  logic [CELL_W-1:0] tok_in_carry,
	output logic              tok_out_valid,
	output logic [CELL_W-1:0] tok_out_carry,
	output logic              hit
);

	logic [CELL_W-1:0] content_q;
	logic              tok_valid_q;
	logic [CELL_W-1:0] tok_carry_q;

	assign hit           = tok_valid_q && (content_q == search);
	assign tok_out_valid = tok_valid_q && !hit;
	assign tok_out_carry = content_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			content_q   <= CELL_W'(INDEX);
			tok_valid_q <= 1'b0;
		end else if (restore) begin
			content_q   <= CELL_W'(INDEX);
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in_valid;
			if (tok_valid_q) begin
				content_q <= tok_carry_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_carry_q <= tok_in_carry;
	end

endmodule

// ===== src/move_to_front_rank.sv =====
// Channel  | Handshake              | Payload
// ---------+------------------------+-----------------------------
// in       | in_valid / in_stall    | item
// out      | out_valid / out_stall  | rank, bad_item
// config   | item_count_we          | item_count
//
// A valid item of rank r gets its result once the search token, walking
// down the row of slots one slot per cycle, meets the item; the rank is then
// registered. An out-of-range item gives its result in the next cycle.
// One item is in flight at a time; the next is taken in the cycle the
// result leaves. Reset and a count write put item i in slot i at once.
// A stalled result holds the output register and blocks new transfers.
module move_to_front_rank #(
	parameter int MAX_ITEMS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_count_we,
	input  logic [mtfr_pkg::CNT_W-1:0]       item_count,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [mtfr_pkg::ITEM_W-1:0]      item,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [mtfr_pkg::RANK_W-1:0]      rank,
	output logic                             bad_item
);

	import mtfr_pkg::*;

	localparam int CELL_W  = $clog2(MAX_ITEMS);
	localparam int RST_CNT = (MAX_ITEMS < RESET_COUNT) ? MAX_ITEMS : RESET_COUNT;

	typedef enum logic {
		IDLE,
		WALK
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [CELL_W-1:0]   search_q;
	logic [CELL_W-1:0]   steps_q;
	logic                out_valid_q;
	logic [RANK_W-1:0]   rank_q;
	logic                bad_q;

	logic                accept;
	logic                item_bad;
	logic                any_hit;
	logic [MAX_ITEMS:0]  tok_valid;
	logic [CELL_W-1:0]   tok_carry [MAX_ITEMS+1];
	logic [MAX_ITEMS-1:0] hit_vec;

	assign in_stall  = (state_q != IDLE) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign item_bad  = {1'b0, item} >= count_q;
	assign any_hit   = |hit_vec;
	assign out_valid = out_valid_q;
	assign rank      = rank_q;
	assign bad_item  = bad_q;

	assign tok_valid[0] = accept && !item_bad;
	assign tok_carry[0] = CELL_W'(item);

	genvar g;
	generate
		for (g = 0; g < MAX_ITEMS; g++) begin : g_cell
			mtfr_cell #(
				.CELL_W (CELL_W),
				.INDEX  (g)
			) u_cell (
				.clk           (clk),
				.arst_n        (arst_n),
				.restore       (item_count_we),
				.search        (search_q),
				.tok_in_valid  (tok_valid[g]),
				.tok_in_carry  (tok_carry[g]),
				.tok_out_valid (tok_valid[g+1]),
				.tok_out_carry (tok_carry[g+1]),
				.hit           (hit_vec[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(RST_CNT);
		end else if (item_count_we) begin
			if (32'(item_count) > MAX_ITEMS) begin
				count_q <= CNT_W'(MAX_ITEMS);
			end else begin
				count_q <= item_count;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
			rank_q      <= '0;
			bad_q       <= 1'b0;
			search_q    <= '0;
			steps_q     <= '0;
		end else begin
			// a flagged item taken as the old result leaves sets valid below
			if (out_valid_q && !out_stall && !(accept && item_bad)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						if (item_bad) begin
							out_valid_q <= 1'b1;
							rank_q      <= '0;
							bad_q       <= 1'b1;
						end else begin
							state_q  <= WALK;
							search_q <= CELL_W'(item);
							steps_q  <= '0;
						end
					end
				end
				WALK: begin
					// the slot index where the token stops is the rank
					if (any_hit) begin
						out_valid_q <= 1'b1;
						rank_q      <= RANK_W'(steps_q);
						bad_q       <= 1'b0;
						state_q     <= IDLE;
					end else begin
						steps_q <= steps_q + 1'b1;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/mtfr_checker.sv =====
module mtfr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [mtfr_pkg::RANK_W-1:0] rank,
	input logic                        bad_item
);

	import mtfr_pkg::*;

	// a flagged item always reports rank zero
	a_bad_rank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_item) |-> (rank == '0))
		else $error("bad item with nonzero rank");

	// after a transfer in, the block is either walking or has a result ready
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (in_stall || out_valid))
		else $error("input transfer left no trace");

	// no new transfer while a result is held back
	a_no_in_on_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && !in_stall && out_valid && out_stall))
		else $error("input taken while result stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(rank) && $stable(bad_item)))
		else $error("stalled result changed");

endmodule

bind move_to_front_rank mtfr_checker u_mtfr_checker (.*);

// ===== tb/mtf_rank_checker.sv =====
`timescale 1ns / 1ps

module mtf_rank_checker #(
	parameter int MAX_ITEMS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_count_we,
	input  logic [mtfr_pkg::CNT_W-1:0]   item_count,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [mtfr_pkg::ITEM_W-1:0]  item,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [mtfr_pkg::RANK_W-1:0]  rank,
	input  logic                         bad_item,
	output int                           fail_count,
	output int                           waiting,
	output int                           items_taken,
	output int                           results_checked,
	output int                           flagged
);
	import mtfr_pkg::*;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic              bad;
	} rank_answer_t;

	int unsigned  place_of [MAX_ITEMS];
	int unsigned  live_count;
	rank_answer_t rank_answers [$];
	int           n_fail;
	int           n_taken;
	int           n_checked;
	int           n_flagged;

	// a count write saturates at capacity and puts item i back at place i
	function automatic void restore_order(input logic [CNT_W-1:0] n);
		live_count = (int'(n) > MAX_ITEMS) ? MAX_ITEMS : n;
		for (int i = 0; i < MAX_ITEMS; i++)
			place_of[i] = i;
	endfunction

	function automatic rank_answer_t mtf_lookup(input logic [ITEM_W-1:0] id);
		rank_answer_t ans;
		int unsigned  depth;
		ans.rank = '0;
		ans.bad  = 1'b1;
		if (int'(id) >= live_count)
			return ans;
		depth = place_of[id];
		for (int i = 0; i < live_count; i++)
			if (place_of[i] < depth)
				place_of[i]++;
		place_of[id] = 0;
		ans.rank = RANK_W'(depth);
		ans.bad  = 1'b0;
		return ans;
	endfunction

	function automatic void note_fail(input string msg);
		n_fail++;
		if (n_fail <= 10)
			$display("%0t ns: %s", $time, msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rank_answer_t want;
		if (!arst_n) begin
			restore_order(CNT_W'(RESET_COUNT));
			rank_answers.delete();
		end else begin
			if (item_count_we)
				restore_order(item_count);
			if (out_valid && !out_stall) begin
				n_checked++;
				if (bad_item)
					n_flagged++;
				if (rank_answers.size() == 0) begin
					note_fail($sformatf("result with nothing pending: rank %0d bad_item %0b",
						rank, bad_item));
				end else begin
					want = rank_answers.pop_front();
					if (rank !== want.rank || bad_item !== want.bad)
						note_fail($sformatf(
							"result %0d: expected rank %0d bad_item %0b, got rank %0d bad_item %0b",
							n_checked, want.rank, want.bad, rank, bad_item));
				end
			end
			if (in_valid && !in_stall) begin
				n_taken++;
				rank_answers.push_back(mtf_lookup(item));
			end
		end
		// copies go out by NBA so readers at the same edge see settled values
		fail_count      <= n_fail;
		waiting         <= rank_answers.size();
		items_taken     <= n_taken;
		results_checked <= n_checked;
		flagged         <= n_flagged;
	end

endmodule

// ===== tb/move_to_front_rank_tb.sv =====
`timescale 1ns / 1ps

module move_to_front_rank_tb;
	import mtfr_pkg::*;

	localparam int MAX_ITEMS    = 1024;
	localparam int RANDOM_ITEMS = 400;
	localparam int DRAIN_CYCLES = 1100;

	logic              clk;
	logic              arst_n;
	logic              item_count_we;
	logic [CNT_W-1:0]  item_count;
	logic              in_valid;
	logic              in_stall;
	logic [ITEM_W-1:0] item;
	logic              out_valid;
	logic              out_stall;
	logic [RANK_W-1:0] rank;
	logic              bad_item;

	int                fail_count;
	int                waiting;
	int                items_taken;
	int                results_checked;
	int                flagged;
	int                settings_done;
	bit                tx_steady;
	bit                rx_steady;
	logic [ITEM_W-1:0] recent [4];

	move_to_front_rank #(
		.MAX_ITEMS(MAX_ITEMS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_count_we(item_count_we),
		.item_count   (item_count),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.item         (item),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.rank         (rank),
		.bad_item     (bad_item)
	);

	mtf_rank_checker #(
		.MAX_ITEMS(MAX_ITEMS)
	) checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_count_we  (item_count_we),
		.item_count     (item_count),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.item           (item),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.rank           (rank),
		.bad_item       (bad_item),
		.fail_count     (fail_count),
		.waiting        (waiting),
		.items_taken    (items_taken),
		.results_checked(results_checked),
		.flagged        (flagged)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	// mostly no gap or a short one, now and then a long one
	function automatic int gap_len(input bit steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_item(input logic [ITEM_W-1:0] v);
		int g;
		g = gap_len(tx_steady);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		item     <= v;
		do
			@(posedge clk);
		while (in_stall);
		recent[3] = recent[2];
		recent[2] = recent[1];
		recent[1] = recent[0];
		recent[0] = v;
	endtask

	// only written with the pipe empty; every item gives one result
	task automatic write_count(input logic [CNT_W-1:0] n);
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (waiting != 0);
		repeat (3) @(posedge clk);
		item_count_we <= 1'b1;
		item_count    <= n;
		@(posedge clk);
		item_count_we <= 1'b0;
		settings_done++;
		tx_steady = ($urandom_range(0, 3) == 0);
		rx_steady = ($urandom_range(0, 3) == 0);
	endtask

	initial begin
		int g;
		int hold;
		bit held;
		held = 1'b0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			// long hold-off so the block backs up and stalls its input
			if ((!held && items_taken >= 60) || $urandom_range(0, 2999) == 0) begin
				hold = $urandom_range(150, 300);
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			g = gap_len(rx_steady);
			if (g > 0) begin
				out_stall <= 1'b1;
				repeat (g) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
		end
	end

	initial begin
		int               sent;
		int               n_items;
		int               pick;
		int               span;
		logic [CNT_W-1:0] setting;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		item          <= '0;
		item_count_we <= 1'b0;
		item_count    <= '0;
		settings_done = 0;
		tx_steady     = 1'b0;
		rx_steady     = 1'b0;
		foreach (recent[i])
			recent[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full stack from reset: top, bottom, repeat, middle
		send_item(0);
		send_item(1023);
		send_item(1023);
		send_item(0);
		send_item(512);
		send_item(1);
		send_item(1023);
		// empty stack flags everything
		write_count(0);
		send_item(0);
		send_item(1023);
		write_count(1);
		send_item(0);
		send_item(1);
		send_item(1023);
		// oversized count saturates at capacity
		write_count(2047);
		send_item(1023);
		send_item(1000);
		send_item(1023);
		write_count(1024);
		send_item(1023);
		write_count(5);
		send_item(4);
		send_item(3);
		send_item(4);
		send_item(5);
		send_item(0);

		// small stacks dominate since a deeper rank means a longer walk
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 4)
				setting = 0;
			else if (pick < 10)
				setting = 1024;
			else if (pick < 15)
				setting = CNT_W'($urandom_range(1025, 2047));
			else if (pick < 22)
				setting = CNT_W'($urandom_range(1, 2));
			else
				setting = CNT_W'($urandom_range(3, 48));
			write_count(setting);
			span    = (int'(setting) > MAX_ITEMS) ? MAX_ITEMS : int'(setting);
			n_items = (span > 64) ? $urandom_range(4, 10) : $urandom_range(20, 50);
			repeat (n_items) begin
				pick = $urandom_range(0, 99);
				if (span == 0 || pick < 8)
					send_item(ITEM_W'($urandom_range(0, 1023)));
				else if (pick < 14 && span < 1024)
					send_item(ITEM_W'(span));
				else if (pick < 40)
					send_item(recent[$urandom_range(0, 3)]);
				else
					send_item(ITEM_W'($urandom_range(0, span - 1)));
				sent++;
			end
		end

		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (waiting != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d items across %0d stack sizes; %0d results checked, %0d flagged bad.",
			items_taken, settings_done + 1, results_checked, flagged);
		$display("Mismatches seen: %0d", fail_count);
		if (fail_count == 0 && waiting == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
